// ----- src/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// RIPEMD-160 engine package
// Round tables, initial chaining values and shared helper functions.
// ----------------------------------------------------------------------------
package rmd_pkg;

  typedef logic [4:0][31:0] line_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PADA,
    ST_PADZ,
    ST_PRE,
    ST_RUN,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam int unsigned NumRounds = 80;
  localparam logic [6:0] LastRound = 7'(NumRounds - 1);

  localparam line_t ChainInit = '{32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] KL [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
                                     32'h8F1BBCDC, 32'hA953FD4E};
  localparam logic [31:0] KR [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                     32'h7A6D76E9, 32'h00000000};

  localparam logic [3:0] WL [80] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
    4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
    4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13};

  localparam logic [3:0] WR [80] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
    4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
    4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11};

  localparam logic [3:0] SL [80] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
    4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
    4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6};

  localparam logic [3:0] SR [80] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
    4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
    4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11};

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] tmp;
    tmp = {v, v} << n;
    return tmp[63:32];
  endfunction

  function automatic logic [31:0] mix(input logic [2:0] sel, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    unique case (sel)
      3'd0:    r = x ^ y ^ z;
      3'd1:    r = (x & y) | (~x & z);
      3'd2:    r = (x | ~y) ^ z;
      3'd3:    r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

endpackage

// ----- src/rmd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rmd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rmd_round.sv -----
// ----------------------------------------------------------------------------
// RIPEMD-160 round
// One step of the left or right compression line.
// ----------------------------------------------------------------------------
module rmd_round import rmd_pkg::*; (
  input  line_t       line_i,
  input  logic [31:0] word_i,
  input  logic [6:0]  round_i,
  input  logic        right_i,
  output line_t       line_o
);

  logic [2:0]  grp;
  logic [2:0]  fsel;
  logic [31:0] k;
  logic [3:0]  s;
  logic [31:0] sum;
  logic [31:0] t;

  always_comb begin
    grp  = round_i[6:4];
    fsel = right_i ? 3'd4 - grp : grp;
    k    = right_i ? KR[grp] : KL[grp];
    s    = right_i ? SR[round_i] : SL[round_i];
    sum  = line_i[0] + mix(fsel, line_i[1], line_i[2], line_i[3]) + word_i + k;
    t    = rotl(sum, {1'b0, s}) + line_i[4];
    line_o[0] = line_i[4];
    line_o[1] = t;
    line_o[2] = line_i[1];
    line_o[3] = rotl(line_i[2], 5'd10);
    line_o[4] = line_i[3];
  end

endmodule

// ----- src/ripemd160_hash_engine.sv -----
// A full block is followed by one load, 80 rounds at one per cycle and one
// fold. End of message: up to 16 word writes of padding, then a load, the
// rounds and a fold per padded block (two blocks when more than 55 bytes
// remain), then 5 output beats. Throughput is set by the round loop reading
// two words per cycle from the block RAM copies. Reset loads the initial
// chaining words and clears counts.
// ----------------------------------------------------------------------------
// RIPEMD-160 hash engine
// Streams message bytes into two word RAM copies, compresses, pads, emits the digest.
// ----------------------------------------------------------------------------
module ripemd160_hash_engine import rmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] cnt_q, cnt_d;
  logic [31:0] word_q, word_d;
  line_t       chain_q, chain_d;
  line_t       lreg_q, lreg_d, rreg_q, rreg_d;
  line_t       lnext, rnext;
  logic [6:0]  round_q, round_d, round_nxt;
  logic [3:0]  wp_q, wp_d;
  logic        fin_q, fin_d, xtra_q, xtra_d, pend_q, pend_d;
  logic [2:0]  oidx_q, oidx_d;

  logic        we;
  logic [3:0]  waddr, raddr_l, raddr_r;
  logic [31:0] wdata, rdata_l, rdata_r;
  logic [31:0] lowmask;

  rmd_ram #(.Width(32), .Depth(16)) u_ram_l (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_l), .rdata_o(rdata_l)
  );

  rmd_ram #(.Width(32), .Depth(16)) u_ram_r (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_r), .rdata_o(rdata_r)
  );

  rmd_round u_round_l (
    .line_i(lreg_q), .word_i(rdata_l), .round_i(round_q), .right_i(1'b0),
    .line_o(lnext)
  );

  rmd_round u_round_r (
    .line_i(rreg_q), .word_i(rdata_r), .round_i(round_q), .right_i(1'b1),
    .line_o(rnext)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      chain_q <= ChainInit;
      round_q <= '0;
      wp_q    <= '0;
      fin_q   <= 1'b0;
      xtra_q  <= 1'b0;
      pend_q  <= 1'b0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
      round_q <= round_d;
      wp_q    <= wp_d;
      fin_q   <= fin_d;
      xtra_q  <= xtra_d;
      pend_q  <= pend_d;
      oidx_q  <= oidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    lreg_q <= lreg_d;
    rreg_q <= rreg_d;
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    chain_d   = chain_q;
    lreg_d    = lreg_q;
    rreg_d    = rreg_q;
    round_d   = round_q;
    wp_d      = wp_q;
    fin_d     = fin_q;
    xtra_d    = xtra_q;
    pend_d    = pend_q;
    oidx_d    = oidx_q;
    we        = 1'b0;
    waddr     = fill_q[5:2];
    wdata     = word_q;
    raddr_l   = WL[0];
    raddr_r   = WR[0];
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    round_nxt = (round_q == LastRound) ? 7'd0 : round_q + 7'd1;
    lowmask   = (32'h1 << {fill_q[1:0], 3'b000}) - 32'h1;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (has_byte_i) begin
            word_d[{fill_q[1:0], 3'b000} +: 8] = data_byte_i;
            wdata  = word_d;
            we     = (fill_q[1:0] == 2'd3);
            fill_d = fill_q + 6'd1;
            cnt_d  = cnt_q + 61'd1;
            if (fill_q == 6'd63) begin
              pend_d  = end_of_message_i;
              state_d = ST_PRE;
            end else if (end_of_message_i) begin
              state_d = ST_PADA;
            end
          end else if (end_of_message_i) begin
            state_d = ST_PADA;
          end
        end
      end
      ST_PADA: begin
        // place the 0x80 marker, clear the lanes above it
        we     = 1'b1;
        wdata  = (word_q & lowmask) | (32'h80 << {fill_q[1:0], 3'b000});
        fin_d  = 1'b1;
        xtra_d = (fill_q >= 6'd56);
        if (fill_q[5:2] == 4'd15) begin
          state_d = ST_PRE;
        end else begin
          wp_d    = fill_q[5:2] + 4'd1;
          state_d = ST_PADZ;
        end
      end
      ST_PADZ: begin
        we    = 1'b1;
        waddr = wp_q;
        if (!xtra_q && wp_q == 4'd14) begin
          wdata = {cnt_q[28:0], 3'b000};
        end else if (!xtra_q && wp_q == 4'd15) begin
          wdata = cnt_q[60:29];
        end else begin
          wdata = '0;
        end
        wp_d = wp_q + 4'd1;
        if (wp_q == 4'd15) begin
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        lreg_d  = chain_q;
        rreg_d  = chain_q;
        round_d = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        // fetch words for the next round while this one computes
        raddr_l = WL[round_nxt];
        raddr_r = WR[round_nxt];
        lreg_d  = lnext;
        rreg_d  = rnext;
        round_d = round_nxt;
        if (round_q == LastRound) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        chain_d[0] = chain_q[1] + lreg_q[2] + rreg_q[3];
        chain_d[1] = chain_q[2] + lreg_q[3] + rreg_q[4];
        chain_d[2] = chain_q[3] + lreg_q[4] + rreg_q[0];
        chain_d[3] = chain_q[4] + lreg_q[0] + rreg_q[1];
        chain_d[4] = chain_q[0] + lreg_q[1] + rreg_q[2];
        if (pend_q) begin
          pend_d  = 1'b0;
          state_d = ST_PADA;
        end else if (fin_q && xtra_q) begin
          xtra_d  = 1'b0;
          wp_d    = '0;
          state_d = ST_PADZ;
        end else if (fin_q) begin
          oidx_d  = '0;
          state_d = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd4) begin
            chain_d = ChainInit;
            fill_d  = '0;
            cnt_d   = '0;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign digest_word_o = chain_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd4);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (oidx_q <= 3'd4))
    else $error("digest word index out of range");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (round_q <= LastRound))
    else $error("round counter out of range");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> (in_ready_o && fill_q == 6'd0))
    else $error("engine not restarted after digest");

endmodule
